// File: design/tisp_pkg.sv
// Shared types and constants for the prefix trie unit.
// Used by tisp_ctrl, tisp_datapath and trie_insert_search_prefix_unit; depends on nothing.
package tisp_pkg;

  // Pool geometry
  localparam int unsigned NODE_COUNT    = 1024;
  localparam int unsigned ALPHABET_SIZE = 26;
  localparam int unsigned NODE_W        = $clog2(NODE_COUNT);
  localparam int unsigned FREE_W        = NODE_W + 1;
  localparam int unsigned SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;
  localparam int unsigned SLOT_W        = $clog2(SLOT_COUNT);

  // Request field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned LETTER_W = 5;

  // Operation codes; the fourth code is ignored
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_MARK,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic lookup;
    logic walk;
    logic mark_read;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic item_last;
    logic out_busy;
  } dp_status_t;

endpackage

// File: design/tisp_ctrl.sv
// Sequencer for the prefix trie unit: clearing pass, request intake and walk steps.
// Depends on tisp_pkg; drives the command struct into tisp_datapath.
module tisp_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [tisp_pkg::FUNC_W-1:0]         func_i,
  output logic                                in_stall_o,
  input  tisp_pkg::dp_status_t                status_i,
  output tisp_pkg::ctrl_cmd_t                 cmd_o
);
  import tisp_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        // drop requests with the undefined operation code
        if (in_valid_i && (func_i <= FUNC_PREFIX)) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        state_d    = status_i.item_last ? ST_MARK : ST_IDLE;
      end
      ST_MARK: begin
        cmd_o.mark_read = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: design/tisp_datapath.sv
// Datapath of the prefix trie unit: child table, end marks, walk state and result register.
// Depends on tisp_pkg; steered by the command struct from tisp_ctrl.
module tisp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tisp_pkg::ctrl_cmd_t                 cmd_i,
  output tisp_pkg::dp_status_t                status_o,
  input  logic [tisp_pkg::FUNC_W-1:0]         func_i,
  input  logic [tisp_pkg::LETTER_W-1:0]       letter_i,
  input  logic                                word_last_i,
  input  logic                                no_letter_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic                                pool_overflow_o,
  output logic [tisp_pkg::FUNC_W-1:0]         op_done_o
);
  import tisp_pkg::*;

  // Storage
  logic [NODE_W-1:0] child_mem [SLOT_COUNT];
  logic              mark_mem  [NODE_COUNT];

  // Captured request
  logic [FUNC_W-1:0]   item_func_q;
  logic [LETTER_W-1:0] item_letter_q;
  logic                item_last_q;
  logic                item_no_letter_q;

  // Walk state
  logic [NODE_W-1:0] walk_node_q, walk_node_d;
  logic              walk_missed_q, walk_missed_d;
  logic              walk_ovf_q, walk_ovf_d;
  logic [FREE_W-1:0] free_next_q, free_next_d;
  logic              root_mark_q;

  // Clearing sweep
  logic [SLOT_W-1:0] clr_q;

  // Memory ports
  logic [SLOT_W-1:0] slot_d, slot_q;
  logic [NODE_W-1:0] child_rd_q;
  logic              mark_rd_q;
  logic              alloc;
  logic              child_we;
  logic [SLOT_W-1:0] child_waddr;
  logic [NODE_W-1:0] child_wdata;
  logic              mark_we;
  logic [NODE_W-1:0] mark_waddr;
  logic              mark_wdata;

  // Result
  logic              walk_ok;
  logic              insert_ok;
  logic              mark_hit;
  logic              res_found;
  logic              res_ovf;
  logic              out_valid_q;
  logic              found_q;
  logic              ovf_q;
  logic [FUNC_W-1:0] op_q;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_func_q      <= func_i;
      item_letter_q    <= letter_i;
      item_last_q      <= word_last_i;
      item_no_letter_q <= no_letter_i;
    end
  end

  // Sweep the child table once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign slot_d = SLOT_W'(walk_node_q) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(item_letter_q);

  // Advance the walk by one letter
  always_comb begin
    walk_node_d   = walk_node_q;
    walk_missed_d = walk_missed_q;
    walk_ovf_d    = walk_ovf_q;
    free_next_d   = free_next_q;
    alloc         = 1'b0;
    if (cmd_i.walk && !item_no_letter_q && !walk_missed_q && !walk_ovf_q) begin
      priority if (32'(item_letter_q) >= ALPHABET_SIZE) begin
        walk_missed_d = 1'b1;
      end else if (child_rd_q != '0) begin
        walk_node_d = child_rd_q;
      end else if (item_func_q != FUNC_INSERT) begin
        walk_missed_d = 1'b1;
      end else if (free_next_q >= FREE_W'(NODE_COUNT)) begin
        walk_ovf_d = 1'b1;
      end else begin
        alloc       = 1'b1;
        walk_node_d = free_next_q[NODE_W-1:0];
        free_next_d = free_next_q + 1'b1;
      end
    end
    // return to the root after every result
    if (cmd_i.finish) begin
      walk_node_d   = '0;
      walk_missed_d = 1'b0;
      walk_ovf_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_node_q   <= '0;
      walk_missed_q <= 1'b0;
      walk_ovf_q    <= 1'b0;
      free_next_q   <= FREE_W'(1);
    end else begin
      walk_node_q   <= walk_node_d;
      walk_missed_q <= walk_missed_d;
      walk_ovf_q    <= walk_ovf_d;
      free_next_q   <= free_next_d;
    end
  end

  // Child table: one write port shared by the sweep and allocation
  assign child_we    = cmd_i.clear_en || alloc;
  assign child_waddr = cmd_i.clear_en ? clr_q : slot_q;
  assign child_wdata = cmd_i.clear_en ? '0 : free_next_q[NODE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      slot_q     <= slot_d;
      child_rd_q <= child_mem[slot_d];
    end
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
  end

  // Result decode
  assign walk_ok   = !walk_missed_q && !walk_ovf_q;
  assign insert_ok = (item_func_q == FUNC_INSERT) && walk_ok;
  assign mark_hit  = (walk_node_q == '0) ? root_mark_q : mark_rd_q;

  always_comb begin
    res_found = walk_ok;
    res_ovf   = 1'b0;
    unique case (item_func_q)
      FUNC_INSERT: res_ovf   = walk_ovf_q;
      FUNC_SEARCH: res_found = walk_ok && mark_hit;
      default:     res_found = walk_ok;
    endcase
  end

  // End marks: cleared on allocation, set on a completed insert; root kept in a flop
  assign mark_we    = alloc || (cmd_i.finish && insert_ok && (walk_node_q != '0));
  assign mark_waddr = alloc ? free_next_q[NODE_W-1:0] : walk_node_q;
  assign mark_wdata = !alloc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_read) begin
      mark_rd_q <= mark_mem[walk_node_q];
    end
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_mark_q <= 1'b0;
    end else if (cmd_i.finish && insert_ok && (walk_node_q == '0)) begin
      root_mark_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q <= res_found;
      ovf_q   <= res_ovf;
      op_q    <= item_func_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign pool_overflow_o = ovf_q;
  assign op_done_o       = op_q;

  assign status_o.clear_done = (clr_q == SLOT_W'(SLOT_COUNT - 1));
  assign status_o.item_last  = item_last_q;
  assign status_o.out_busy   = out_valid_q && out_stall_i;

  // Checks
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_next_q <= FREE_W'(NODE_COUNT))
    else $error("free counter beyond pool");

  a_walk_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FREE_W'(walk_node_q) < free_next_q)
    else $error("walk on an unallocated node");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(walk_missed_q && walk_ovf_q))
    else $error("miss and overflow both set");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (walk_node_q == '0) && !walk_missed_q && !walk_ovf_q && out_valid_q)
    else $error("walk not back at root after result");

endmodule

// File: design/trie_insert_search_prefix_unit.sv
// Top level of the 26-way prefix trie unit.
// Depends on tisp_pkg, tisp_ctrl and tisp_datapath.
//
// Takes one letter per request and walks a trie held in a pool of 1024 nodes.
// After reset the unit sweeps all 26624 entries of the child table, one entry
// a cycle, with in_stall_o high. A request that does not end a word passes
// through capture, child table read and walk update; a request that ends a
// word then also reads the end mark and waits for the result register to be
// free, since the end mark is read from the node reached by the final letter.
// This order comes from the child table and end-mark memories, each with a
// registered read. Requests with the undefined operation code are taken and
// dropped while the unit stays idle. A finished result sits in an output
// register, so the next request is taken while it waits; the unit only holds
// when a second result is ready before the first has gone.
module trie_insert_search_prefix_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tisp_pkg::FUNC_W-1:0]         func_i,
  input  logic [tisp_pkg::LETTER_W-1:0]       letter_i,
  input  logic                                word_last_i,
  input  logic                                no_letter_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic                                pool_overflow_o,
  output logic [tisp_pkg::FUNC_W-1:0]         op_done_o
);
  import tisp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tisp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tisp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .func_i          (func_i),
    .letter_i        (letter_i),
    .word_last_i     (word_last_i),
    .no_letter_i     (no_letter_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .pool_overflow_o (pool_overflow_o),
    .op_done_o       (op_done_o)
  );

endmodule

// File: dv/trie_insert_search_prefix_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 26-way prefix trie unit.
// Depends on tisp_pkg and trie_insert_search_prefix_unit; predicts each result from its own trie copy.
module trie_insert_search_prefix_unit_tb;
  import tisp_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;
  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned MAX_LEN      = 12;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic              found;
    logic              ovf;
    logic [FUNC_W-1:0] op;
  } trie_result_t;

  typedef struct packed {
    logic [3:0]                        len;
    logic [MAX_LEN-1:0][LETTER_W-1:0] ch;
  } word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i;
  logic [LETTER_W-1:0] letter_i;
  logic                word_last_i;
  logic                no_letter_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                found_o;
  logic                pool_overflow_o;
  logic [FUNC_W-1:0]   op_done_o;

  // Predicted trie state
  logic [NODE_W-1:0] child_tab [SLOT_COUNT];
  logic              end_mark  [NODE_COUNT];
  logic [FREE_W-1:0] free_cnt;
  logic [NODE_W-1:0] walk_at;
  logic              walk_miss;
  logic              walk_ovf;
  bit                pool_full_seen;

  trie_result_t pending_results [$];
  trie_result_t head_r;
  word_t        dict_words [$];
  int unsigned  fail_cnt   = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycle_cnt  = 0;
  bit           idle_en    = 1'b1;
  bit           stall_en   = 1'b1;

  trie_insert_search_prefix_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .letter_i       (letter_i),
    .word_last_i    (word_last_i),
    .no_letter_i    (no_letter_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .pool_overflow_o(pool_overflow_o),
    .op_done_o      (op_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the predicted walk by one request; queue a result when the word ends
  function automatic void trie_walk_request(input logic [FUNC_W-1:0] f,
                                            input logic [LETTER_W-1:0] l,
                                            input logic last, input logic empty);
    int unsigned       slot;
    logic [NODE_W-1:0] child;
    trie_result_t      r;
    if (f == FUNC_UNDEF) return;
    if (!empty && !walk_miss && !walk_ovf) begin
      if (l >= ALPHABET_SIZE) begin
        walk_miss = 1'b1;
      end else begin
        slot  = walk_at * ALPHABET_SIZE + l;
        child = child_tab[slot];
        if (child != '0) begin
          walk_at = child;
        end else if (f != FUNC_INSERT) begin
          walk_miss = 1'b1;
        end else if (free_cnt >= NODE_COUNT) begin
          walk_ovf       = 1'b1;
          pool_full_seen = 1'b1;
        end else begin
          child           = free_cnt[NODE_W-1:0];
          free_cnt        = free_cnt + 1'b1;
          end_mark[child] = 1'b0;
          child_tab[slot] = child;
          walk_at         = child;
        end
      end
    end
    if (!last) return;
    r    = '0;
    r.op = f;
    case (f)
      FUNC_INSERT: begin
        if (walk_ovf) begin
          r.ovf = 1'b1;
        end else if (!walk_miss) begin
          end_mark[walk_at] = 1'b1;
          r.found           = 1'b1;
        end
      end
      FUNC_SEARCH: r.found = !walk_miss && !walk_ovf && end_mark[walk_at];
      default:     r.found = !walk_miss && !walk_ovf;
    endcase
    pending_results.push_back(r);
    walk_at   = '0;
    walk_miss = 1'b0;
    walk_ovf  = 1'b0;
  endfunction

  // Drive one request, hold it while stalled, predict on acceptance
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [LETTER_W-1:0] l,
                              input logic last, input logic empty);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    letter_i    <= l;
    word_last_i <= last;
    no_letter_i <= empty;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    trie_walk_request(f, l, last, empty);
    if (f != FUNC_UNDEF) items_sent++;
  endtask

  function automatic word_t rand_word(input int unsigned min_len, input int unsigned max_len,
                                      input bit narrow, input bit allow_oor);
    word_t w;
    w     = '0;
    w.len = 4'($urandom_range(max_len, min_len));
    for (int i = 0; i < MAX_LEN; i++) begin
      if (narrow) w.ch[i] = LETTER_W'($urandom_range(3));
      else if (allow_oor && $urandom_range(19) == 0) w.ch[i] = LETTER_W'($urandom_range(31, 26));
      else w.ch[i] = LETTER_W'($urandom_range(ALPHABET_SIZE - 1));
    end
    return w;
  endfunction

  // Send a whole word; noisy words carry dropped codes, empty items and mixed operations
  task automatic send_word(input word_t w, input logic [FUNC_W-1:0] f, input bit noisy);
    bit                tail_empty;
    logic [FUNC_W-1:0] item_f;
    tail_empty = noisy && ($urandom_range(6) == 0);
    if (w.len == 0) begin
      send_request(f, LETTER_W'($urandom_range(31)), 1'b1, 1'b1);
      return;
    end
    for (int i = 0; i < w.len; i++) begin
      if (noisy && $urandom_range(6) == 0)
        send_request(FUNC_UNDEF, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
      if (noisy && $urandom_range(9) == 0)
        send_request(FUNC_W'($urandom_range(2)), LETTER_W'($urandom_range(31)), 1'b0, 1'b1);
      item_f = f;
      if (noisy && $urandom_range(4) == 0) item_f = FUNC_W'($urandom_range(2));
      if (i == w.len - 1 && !tail_empty) send_request(f, w.ch[i], 1'b1, 1'b0);
      else send_request(item_f, w.ch[i], 1'b0, 1'b0);
    end
    if (tail_empty) send_request(f, LETTER_W'($urandom_range(31)), 1'b1, 1'b1);
  endtask

  // Pick a stored word, sometimes cut short or lengthened by one letter
  function automatic word_t known_word();
    word_t w;
    if (dict_words.size() == 0) return rand_word(1, 4, 1'b1, 1'b0);
    w = dict_words[$urandom_range(dict_words.size() - 1)];
    case ($urandom_range(3))
      0: if (w.len > 1) w.len = 4'($urandom_range(w.len - 1, 1));
      1: if (w.len < MAX_LEN) w.len = w.len + 4'd1;
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_empty_words();
    send_request(FUNC_SEARCH, 5'd31, 1'b1, 1'b1);
    send_request(FUNC_PREFIX, 5'd0, 1'b1, 1'b1);
    send_request(FUNC_INSERT, 5'd17, 1'b1, 1'b1);
    send_request(FUNC_SEARCH, 5'd0, 1'b1, 1'b1);
  endtask

  task automatic test_letter_extremes();
    send_request(FUNC_INSERT, 5'd0, 1'b1, 1'b0);
    send_request(FUNC_INSERT, 5'd25, 1'b1, 1'b0);
    send_request(FUNC_SEARCH, 5'd0, 1'b1, 1'b0);
    send_request(FUNC_SEARCH, 5'd1, 1'b1, 1'b0);
    send_request(FUNC_PREFIX, 5'd25, 1'b1, 1'b0);
    send_request(FUNC_INSERT, 5'd0, 1'b0, 1'b0);
    send_request(FUNC_INSERT, 5'd1, 1'b1, 1'b0);
    send_request(FUNC_SEARCH, 5'd0, 1'b0, 1'b0);
    send_request(FUNC_SEARCH, 5'd1, 1'b0, 1'b0);
    send_request(FUNC_SEARCH, 5'd2, 1'b1, 1'b0);
  endtask

  task automatic test_out_of_range();
    send_request(FUNC_INSERT, 5'd0, 1'b0, 1'b0);
    send_request(FUNC_INSERT, 5'd26, 1'b1, 1'b0);
    send_request(FUNC_SEARCH, 5'd31, 1'b1, 1'b0);
    send_request(FUNC_PREFIX, 5'd27, 1'b1, 1'b0);
  endtask

  task automatic test_undefined_op();
    send_request(FUNC_UNDEF, 5'd0, 1'b1, 1'b0);
    send_request(FUNC_SEARCH, 5'd0, 1'b0, 1'b0);
    send_request(FUNC_UNDEF, 5'd31, 1'b1, 1'b1);
    send_request(FUNC_SEARCH, 5'd1, 1'b1, 1'b0);
  endtask

  task automatic test_mixed_ops();
    // prefix walk then insert finishes the word
    send_request(FUNC_PREFIX, 5'd0, 1'b0, 1'b0);
    send_request(FUNC_INSERT, 5'd2, 1'b1, 1'b0);
    // miss on search, insert afterwards marks nothing
    send_request(FUNC_SEARCH, 5'd23, 1'b0, 1'b0);
    send_request(FUNC_INSERT, 5'd24, 1'b1, 1'b0);
  endtask

  // Well-formed words with random content, with noisy and broken words mixed in
  task automatic test_random_words(input int unsigned item_budget);
    int unsigned stop_at;
    int unsigned pick;
    word_t       w;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        w = rand_word(1, 8, 1'($urandom_range(1)), 1'b0);
        send_word(w, FUNC_INSERT, $urandom_range(4) == 0);
        dict_words.push_back(w);
      end else if (pick < 60) begin
        send_word(known_word(), FUNC_SEARCH, $urandom_range(5) == 0);
      end else if (pick < 75) begin
        send_word(known_word(), FUNC_PREFIX, $urandom_range(5) == 0);
      end else begin
        w = rand_word(1, 6, 1'($urandom_range(1)), 1'b1);
        if ($urandom_range(9) == 0) w.len = '0;
        send_word(w, FUNC_W'($urandom_range(2)), 1'b1);
      end
      if ($urandom_range(29) == 0) begin
        idle_en  = ~idle_en;
        stall_en = ~stall_en;
      end
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  // Long random inserts until the pool runs dry; first half with no idling
  task automatic test_pool_exhaust();
    word_t w;
    idle_en  = 1'b0;
    stall_en = 1'b0;
    while (!pool_full_seen) begin
      if (free_cnt > NODE_COUNT / 2) begin
        idle_en  = 1'b1;
        stall_en = 1'b1;
      end
      send_word(rand_word(MAX_LEN, MAX_LEN, 1'b0, 1'b0), FUNC_INSERT, 1'b0);
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
    // insert overflows, then search or prefix closes the same word
    for (int k = 0; k < 6; k++) begin
      w = rand_word(4, 4, 1'b0, 1'b0);
      for (int i = 0; i < 3; i++) send_request(FUNC_INSERT, w.ch[i], 1'b0, 1'b0);
      send_request((k % 2) ? FUNC_SEARCH : FUNC_PREFIX, w.ch[3], 1'b1, 1'b0);
    end
    // stored words still insert and search cleanly
    for (int k = 0; k < 6 && k < dict_words.size(); k++) begin
      send_word(dict_words[k], FUNC_INSERT, 1'b0);
      send_word(dict_words[k], FUNC_SEARCH, 1'b0);
    end
  endtask

  // Check each accepted result against the oldest prediction; stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: found %0b pool_overflow %0b op_done %0d",
               found_o, pool_overflow_o, op_done_o);
        fail_cnt++;
      end else begin
        head_r = pending_results.pop_front();
        if (found_o !== head_r.found) begin
          $error("found: expected %0b, actual %0b", head_r.found, found_o);
          fail_cnt++;
        end
        if (pool_overflow_o !== head_r.ovf) begin
          $error("pool_overflow: expected %0b, actual %0b", head_r.ovf, pool_overflow_o);
          fail_cnt++;
        end
        if (op_done_o !== head_r.op) begin
          $error("op_done: expected %0d, actual %0d", head_r.op, op_done_o);
          fail_cnt++;
        end
      end
    end
    out_stall_i <= stall_en && ($urandom_range(99) < IDLE_PCT);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_INSERT;
    letter_i    <= '0;
    word_last_i <= 1'b0;
    no_letter_i <= 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) child_tab[i] = '0;
    for (int i = 0; i < NODE_COUNT; i++) end_mark[i] = 1'b0;
    free_cnt       = FREE_W'(1);
    walk_at        = '0;
    walk_miss      = 1'b0;
    walk_ovf       = 1'b0;
    pool_full_seen = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_words();
    test_letter_extremes();
    test_out_of_range();
    test_undefined_op();
    test_mixed_ops();
    test_random_words(400);
    test_pool_exhaust();
    test_random_words(120);

    // Drain outstanding results, then allow for late extras
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
